FILE: src/baro_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// baro_pkg
// Shared types and constants for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package baro_pkg;

    localparam int CFG_DATA_W = 48;
    localparam int RAW_W      = 24;
    localparam int TEMP_W     = 24;
    localparam int PRESS_W    = 32;
    localparam int PIPE_DEPTH = 11;

    // calibration offset applied to P1 and P2
    localparam logic signed [17:0] P_OFFSET = 18'sd16384;

    typedef enum logic [1:0] {
        CFG_TEMP_CALIB,
        CFG_PRESS_A,
        CFG_PRESS_B,
        CFG_PRESS_C
    } t_cfg_idx;

endpackage
`default_nettype wire

FILE: src/baro_pressure_temp_compensation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Polynomial compensation of raw pressure and temperature readings in exact
// fixed point, evaluated by Horner steps over an eleven stage pipeline.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  in        sink       i_in_valid / o_in_stall       i_raw_pressure, i_raw_temperature
//  out       source     o_out_valid / i_out_stall     o_temperature_fixed, o_pressure_fixed,
//                                                     o_clamped
//  cfg       sink       i_cfg_we                      i_cfg_index, i_cfg_data
//
//  one transaction per cycle; the pipeline depth is set by the chain of
//  dependent multiplies (temperature polynomial, three Horner steps in t,
//  one step in the raw pressure), with the wide products split into partials.
//  synchronous active-low reset clears the valid bits and calibration words.
//  a stall on the output holds the whole pipeline and stalls the input.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [baro_pkg::RAW_W-1:0]            i_raw_pressure,
    input  logic [baro_pkg::RAW_W-1:0]            i_raw_temperature,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [baro_pkg::TEMP_W-1:0]    o_temperature_fixed,
    output logic [baro_pkg::PRESS_W-1:0]          o_pressure_fixed,
    output logic                                  o_clamped,
    input  logic                                  i_cfg_we,
    input  baro_pkg::t_cfg_idx                    i_cfg_index,
    input  logic [baro_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import baro_pkg::*;

    // calibration registers
    logic [39:0] r_temp_calib;
    logic [47:0] r_press_a;
    logic [47:0] r_press_b;
    logic [31:0] r_press_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_calib <= '0;
            r_press_a    <= '0;
            r_press_b    <= '0;
            r_press_c    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TEMP_CALIB: r_temp_calib <= i_cfg_data[39:0];
                CFG_PRESS_A:    r_press_a    <= i_cfg_data[47:0];
                CFG_PRESS_B:    r_press_b    <= i_cfg_data[47:0];
                CFG_PRESS_C:    r_press_c    <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    logic [15:0]        w_t1, w_t2, w_p5, w_p6;
    logic signed [7:0]  w_t3, w_p3, w_p4, w_p7, w_p8, w_p10, w_p11;
    logic signed [15:0] w_p1, w_p2, w_p9;
    logic signed [17:0] w_p1m, w_p2m;

    assign w_t1  = r_temp_calib[15:0];
    assign w_t2  = r_temp_calib[31:16];
    assign w_t3  = $signed(r_temp_calib[39:32]);
    assign w_p1  = $signed(r_press_a[15:0]);
    assign w_p2  = $signed(r_press_a[31:16]);
    assign w_p3  = $signed(r_press_a[39:32]);
    assign w_p4  = $signed(r_press_a[47:40]);
    assign w_p5  = r_press_b[15:0];
    assign w_p6  = r_press_b[31:16];
    assign w_p7  = $signed(r_press_b[39:32]);
    assign w_p8  = $signed(r_press_b[47:40]);
    assign w_p9  = $signed(r_press_c[15:0]);
    assign w_p10 = $signed(r_press_c[23:16]);
    assign w_p11 = $signed(r_press_c[31:24]);
    assign w_p1m = 18'(w_p1) - P_OFFSET;
    assign w_p2m = 18'(w_p2) - P_OFFSET;

    // pipeline control
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  w_adv;

    assign w_adv       = !r_vld[PIPE_DEPTH-1] || !i_out_stall;
    assign o_in_stall  = !w_adv;
    assign o_out_valid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in_valid};
        end
    end

    // stage 1: temperature offset
    logic signed [25:0] n1_d, r1_d;
    logic [23:0]        r1_up;
    assign n1_d = $signed({2'b00, i_raw_temperature}) - $signed({2'b00, w_t1, 8'h00});

    // stage 2: d*T2 and d^2
    logic signed [42:0] w2_m1, r2_m1;
    logic signed [51:0] w2_dd, r2_dd;
    logic [23:0]        r2_up;
    assign w2_m1 = r1_d * $signed({1'b0, w_t2});
    assign w2_dd = r1_d * r1_d;

    // stage 3: t in 2^-48 units
    logic signed [59:0] w3_ddt;
    logic signed [61:0] n3_tn, r3_tn;
    logic [23:0]        r3_up;
    assign w3_ddt = r2_dd * w_t3;
    assign n3_tn  = (62'(r2_m1) <<< 18) + 62'(w3_ddt);

    // stage 4: rounding to output temperature and to tq
    logic signed [61:0] w4_rt, w4_rq;
    logic signed [23:0] n4_tf, r4_tf;
    logic signed [29:0] n4_tq, r4_tq;
    logic [23:0]        r4_up;
    assign w4_rt = r3_tn + 62'sh80_0000_0000;
    assign w4_rq = r3_tn + 62'sh8000_0000;
    // |tn| < 2^60 keeps the rounded temperature inside 22 bits, never saturates
    assign n4_tf = {{2{w4_rt[61]}}, w4_rt[61:40]};
    assign n4_tq = w4_rq[61:32];

    // stage 5: first Horner step in t, up-side inner term
    logic signed [37:0] w5_a1m, w5_b1m, n5_a1, n5_b1, r5_a1, r5_b1;
    logic signed [38:0] w5_e1;
    logic signed [32:0] w5_e2;
    logic signed [40:0] n5_e, r5_e;
    logic signed [29:0] r5_tq;
    logic signed [23:0] r5_tf;
    logic [23:0]        r5_up;
    assign w5_a1m = w_p8 * r4_tq;
    assign w5_b1m = w_p4 * r4_tq;
    assign n5_a1  = w5_a1m + (38'(w_p7) <<< 23);
    assign n5_b1  = w5_b1m + (38'(w_p3) <<< 21);
    assign w5_e1  = w_p10 * r4_tq;
    assign w5_e2  = $signed({1'b0, r4_up}) * w_p11;
    assign n5_e   = (41'(w_p9) <<< 17) + (41'(w5_e1) <<< 1) + 41'(w5_e2);

    // stage 6: second Horner step, up times inner term
    logic signed [67:0] w6_a2m, w6_b2m, n6_a2, n6_b2, r6_a2, r6_b2;
    logic signed [65:0] w6_ue, r6_ue;
    logic signed [29:0] r6_tq;
    logic signed [23:0] r6_tf;
    logic [23:0]        r6_up;
    assign w6_a2m = r5_a1 * r5_tq;
    assign w6_b2m = r5_b1 * r5_tq;
    assign n6_a2  = w6_a2m + (68'($signed({1'b0, w_p6})) <<< 41);
    assign n6_b2  = w6_b2m + (68'(w_p2m) <<< 40);
    assign w6_ue  = $signed({1'b0, r5_up}) * r5_e;

    // stage 7: third Horner step as split partial products
    logic signed [64:0] w7_alo, w7_blo, r7_alo, r7_blo;
    logic signed [63:0] w7_ahi, w7_bhi, r7_ahi, r7_bhi;
    logic signed [65:0] r7_ue;
    logic signed [23:0] r7_tf;
    logic [23:0]        r7_up;
    assign w7_alo = $signed({1'b0, r6_a2[33:0]}) * r6_tq;
    assign w7_ahi = $signed(r6_a2[67:34]) * r6_tq;
    assign w7_blo = $signed({1'b0, r6_b2[33:0]}) * r6_tq;
    assign w7_bhi = $signed(r6_b2[67:34]) * r6_tq;

    // stage 8: recombine, A/2^22 and the up-polynomial F
    logic signed [98:0] n8_a3, r8_a3;
    logic signed [99:0] n8_f, r8_f;
    logic signed [23:0] r8_tf;
    logic [23:0]        r8_up;
    assign n8_a3 = (99'(r7_ahi) <<< 34) + 99'(r7_alo)
                 + (99'($signed({1'b0, w_p5})) <<< 66);
    assign n8_f  = (100'(r7_bhi) <<< 34) + 100'(r7_blo)
                 + (100'(w_p1m) <<< 65) + (100'(r7_ue) <<< 20);

    // stage 9: up times F in three slices
    logic signed [59:0] w9_p0, w9_p1, r9_p0, r9_p1;
    logic signed [56:0] w9_p2, r9_p2;
    logic signed [98:0] r9_a3;
    logic signed [23:0] r9_tf;
    assign w9_p0 = $signed({1'b0, r8_up}) * $signed({1'b0, r8_f[33:0]});
    assign w9_p1 = $signed({1'b0, r8_up}) * $signed({1'b0, r8_f[67:34]});
    assign w9_p2 = $signed({1'b0, r8_up}) * $signed(r8_f[99:68]);

    // stage 10: full sum in 2^-85 Pa with rounding bias
    logic signed [127:0] n10_sum, r10_sum;
    logic signed [23:0]  r10_tf;
    assign n10_sum = (128'(r9_a3) <<< 22) + (128'(r9_p2) <<< 68) + (128'(r9_p1) <<< 34)
                   + 128'(r9_p0) + (128'sd1 <<< 76);

    // stage 11: saturate to output range
    logic [31:0]        n11_pf, r11_pf;
    logic               n11_cl, r11_cl;
    logic signed [23:0] r11_tf;
    always_comb begin
        n11_pf = r10_sum[108:77];
        n11_cl = 1'b0;
        if (r10_sum[127]) begin
            n11_pf = '0;
            n11_cl = 1'b1;
        end else if (|r10_sum[126:109]) begin
            n11_pf = '1;
            n11_cl = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_d    <= n1_d;
            r1_up   <= i_raw_pressure;
            r2_m1   <= w2_m1;
            r2_dd   <= w2_dd;
            r2_up   <= r1_up;
            r3_tn   <= n3_tn;
            r3_up   <= r2_up;
            r4_tf   <= n4_tf;
            r4_tq   <= n4_tq;
            r4_up   <= r3_up;
            r5_a1   <= n5_a1;
            r5_b1   <= n5_b1;
            r5_e    <= n5_e;
            r5_tq   <= r4_tq;
            r5_tf   <= r4_tf;
            r5_up   <= r4_up;
            r6_a2   <= n6_a2;
            r6_b2   <= n6_b2;
            r6_ue   <= w6_ue;
            r6_tq   <= r5_tq;
            r6_tf   <= r5_tf;
            r6_up   <= r5_up;
            r7_alo  <= w7_alo;
            r7_ahi  <= w7_ahi;
            r7_blo  <= w7_blo;
            r7_bhi  <= w7_bhi;
            r7_ue   <= r6_ue;
            r7_tf   <= r6_tf;
            r7_up   <= r6_up;
            r8_a3   <= n8_a3;
            r8_f    <= n8_f;
            r8_tf   <= r7_tf;
            r8_up   <= r7_up;
            r9_p0   <= w9_p0;
            r9_p1   <= w9_p1;
            r9_p2   <= w9_p2;
            r9_a3   <= r8_a3;
            r9_tf   <= r8_tf;
            r10_sum <= n10_sum;
            r10_tf  <= r9_tf;
            r11_pf  <= n11_pf;
            r11_cl  <= n11_cl;
            r11_tf  <= r10_tf;
        end
    end

    assign o_temperature_fixed = r11_tf;
    assign o_pressure_fixed    = r11_pf;
    assign o_clamped           = r11_cl;

    // a held pipeline keeps every valid bit in place
    a_hold_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("valid bits moved while pipeline held");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_vld[0])
        else $error("accepted transaction lost at pipeline entry");

    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clamped) |->
        (o_pressure_fixed == '0 || o_pressure_fixed == '1))
        else $error("clamp flag without saturated pressure");

endmodule
`default_nettype wire
